// File: rtl/url_qsd_pkg.sv
// Shared types, character codes and decode helpers for the query splitter.
package url_qsd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_KEY        = 2'd0;
    localparam logic [1:0] KIND_VALUE      = 2'd1;
    localparam logic [1:0] KIND_PAIR_END   = 2'd2;
    localparam logic [1:0] KIND_TARGET_END = 2'd3;

    // Parser phases
    localparam logic [1:0] PH_PRE   = 2'd0;
    localparam logic [1:0] PH_KEY   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    // Escape hold states
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_PCT  = 2'd1;
    localparam logic [1:0] HOLD_BYTE = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    localparam int HEX_BASE_LOG2 = 4;

    // Most results one input byte can cause
    localparam int RES_MAX = 4;
    localparam int RES_IW  = $clog2(RES_MAX);
    localparam int RES_CW  = $clog2(RES_MAX + 1);

    // Results of one input byte, in order
    typedef struct packed {
        logic [RES_CW-1:0]             cnt;
        logic [RES_MAX-1:0][1:0]       kind;
        logic [RES_MAX-1:0][7:0]       data;
    } bundle_t;

    // Map '+' to a space
    function automatic logic [7:0] plain_char(input logic [7:0] b);
        return (b == CH_PLUS) ? CH_SPACE : b;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Hex digit value; bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            t = c - CH_ZERO;
            return {1'b1, t[3:0]};
        end
        if (c inside {[8'h61:8'h66]})
        begin
            t = c - CH_LA + 8'd10;
            return {1'b1, t[3:0]};
        end
        if (c inside {[8'h41:8'h46]})
        begin
            t = c - CH_UA + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    // Read two characters as a base-16 number: leading space, sign, digits
    function automatic logic [7:0] hex_decode(input logic [7:0] c0, input logic [7:0] c1);
        logic [1:0][7:0] c;
        logic [7:0]      val;
        logic            neg;
        logic            lead;
        logic            stop;
        logic [4:0]      h;
        c    = {c1, c0};
        val  = 8'd0;
        neg  = 1'b0;
        lead = 1'b1;
        stop = 1'b0;
        for (int j = 0; j < 2; j++)
        begin
            h = hex_digit(c[j]);
            if (!stop)
            begin
                if (lead)
                begin
                    if (!is_space(c[j]))
                    begin
                        lead = 1'b0;
                        if (c[j] == CH_PLUS || c[j] == CH_MINUS)
                        begin
                            neg = (c[j] == CH_MINUS);
                        end
                        else if (h[4])
                        begin
                            val = {val[7-HEX_BASE_LOG2:0], h[3:0]};
                        end
                        else
                        begin
                            stop = 1'b1;
                        end
                    end
                end
                else if (h[4])
                begin
                    val = {val[7-HEX_BASE_LOG2:0], h[3:0]};
                end
                else
                begin
                    stop = 1'b1;
                end
            end
        end
        return neg ? (8'd0 - val) : val;
    endfunction

endpackage

// File: rtl/url_qsd_front.sv
// Front end: parses each byte and forms the bundle of results it causes.
module url_qsd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          byte_req,
    input  logic                final_req,
    output url_qsd_pkg::bundle_t bundle
);

    logic [1:0] phase_reg, phase_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       pair_open_reg, pair_open_next;
    logic       boundary;
    logic       consumed;
    logic [1:0] dkind;
    url_qsd_pkg::bundle_t bun;

    // Append one result if room is left
    function automatic url_qsd_pkg::bundle_t push(input url_qsd_pkg::bundle_t b,
                                                  input logic [1:0] k,
                                                  input logic [7:0] d);
        url_qsd_pkg::bundle_t r;
        r = b;
        if (r.cnt < url_qsd_pkg::RES_CW'(url_qsd_pkg::RES_MAX))
        begin
            r.kind[r.cnt[url_qsd_pkg::RES_IW-1:0]] = k;
            r.data[r.cnt[url_qsd_pkg::RES_IW-1:0]] = d;
            r.cnt = r.cnt + 1'b1;
        end
        return r;
    endfunction

    // Parse the byte against the current state
    always_comb
    begin
        phase_next      = phase_reg;
        held_count_next = held_count_reg;
        held_byte_next  = held_byte_reg;
        pair_open_next  = pair_open_reg;
        bun             = '0;
        consumed        = 1'b0;
        boundary        = (byte_req == url_qsd_pkg::CH_AMP) ||
                          (phase_reg == url_qsd_pkg::PH_KEY &&
                           byte_req == url_qsd_pkg::CH_EQ);
        dkind           = (phase_reg == url_qsd_pkg::PH_VALUE) ?
                          url_qsd_pkg::KIND_VALUE : url_qsd_pkg::KIND_KEY;

        if (phase_reg == url_qsd_pkg::PH_PRE)
        begin
            if (byte_req == url_qsd_pkg::CH_QMARK)
            begin
                phase_next = url_qsd_pkg::PH_KEY;
            end
        end
        else
        begin
            // Resolve a pending escape first
            if (held_count_reg != url_qsd_pkg::HOLD_NONE)
            begin
                if (boundary)
                begin
                    bun = push(bun, dkind, url_qsd_pkg::CH_PCT);
                    if (held_count_reg == url_qsd_pkg::HOLD_BYTE)
                    begin
                        bun = push(bun, dkind, url_qsd_pkg::plain_char(held_byte_reg));
                    end
                    held_count_next = url_qsd_pkg::HOLD_NONE;
                    held_byte_next  = 8'd0;
                end
                else if (held_count_reg == url_qsd_pkg::HOLD_PCT)
                begin
                    held_byte_next  = byte_req;
                    held_count_next = url_qsd_pkg::HOLD_BYTE;
                    consumed        = 1'b1;
                end
                else
                begin
                    bun = push(bun, dkind, url_qsd_pkg::hex_decode(held_byte_reg, byte_req));
                    held_count_next = url_qsd_pkg::HOLD_NONE;
                    held_byte_next  = 8'd0;
                    consumed        = 1'b1;
                end
            end
            // Ordinary byte handling
            if (!consumed)
            begin
                if (byte_req == url_qsd_pkg::CH_AMP)
                begin
                    if (pair_open_reg)
                    begin
                        bun = push(bun, url_qsd_pkg::KIND_PAIR_END, 8'd0);
                    end
                    pair_open_next = 1'b0;
                    phase_next     = url_qsd_pkg::PH_KEY;
                end
                else if (byte_req == url_qsd_pkg::CH_EQ &&
                         phase_reg == url_qsd_pkg::PH_KEY)
                begin
                    phase_next     = url_qsd_pkg::PH_VALUE;
                    pair_open_next = 1'b1;
                end
                else if (byte_req == url_qsd_pkg::CH_PCT)
                begin
                    held_count_next = url_qsd_pkg::HOLD_PCT;
                    pair_open_next  = 1'b1;
                end
                else
                begin
                    bun = push(bun, dkind, url_qsd_pkg::plain_char(byte_req));
                    pair_open_next = 1'b1;
                end
            end
        end

        // Close out the target on the final byte
        if (final_req)
        begin
            dkind = (phase_next == url_qsd_pkg::PH_VALUE) ?
                    url_qsd_pkg::KIND_VALUE : url_qsd_pkg::KIND_KEY;
            if (held_count_next != url_qsd_pkg::HOLD_NONE)
            begin
                bun = push(bun, dkind, url_qsd_pkg::CH_PCT);
                if (held_count_next == url_qsd_pkg::HOLD_BYTE)
                begin
                    bun = push(bun, dkind, url_qsd_pkg::plain_char(held_byte_next));
                end
            end
            if (pair_open_next)
            begin
                bun = push(bun, url_qsd_pkg::KIND_PAIR_END, 8'd0);
            end
            bun = push(bun, url_qsd_pkg::KIND_TARGET_END, 8'd0);
            phase_next      = url_qsd_pkg::PH_PRE;
            held_count_next = url_qsd_pkg::HOLD_NONE;
            held_byte_next  = 8'd0;
            pair_open_next  = 1'b0;
        end
    end

    assign bundle = bun;

    // Advance parser state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= url_qsd_pkg::PH_PRE;
            held_count_reg <= url_qsd_pkg::HOLD_NONE;
            held_byte_reg  <= 8'd0;
            pair_open_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            held_count_reg <= held_count_next;
            held_byte_reg  <= held_byte_next;
            pair_open_reg  <= pair_open_next;
        end
    end

endmodule

// File: rtl/url_qsd_queue.sv
// Two-entry bundle queue between the parser and the result serializer.
module url_qsd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  url_qsd_pkg::bundle_t push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output url_qsd_pkg::bundle_t head
);

    url_qsd_pkg::bundle_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];

    // Update pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store bundle payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/url_qsd_back.sv
// Back end: walks the head bundle one result per cycle into the output register while stall is low.
module url_qsd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  url_qsd_pkg::bundle_t head,
    output logic                 pop,
    output logic                 valid,
    input  logic                 stall,
    output logic [1:0]           kind,
    output logic [7:0]           data,
    output logic                 last
);

    logic                           valid_reg;
    logic [1:0]                     kind_reg;
    logic [7:0]                     data_reg;
    logic                           last_reg;
    logic [url_qsd_pkg::RES_IW-1:0] idx_reg, idx_next;
    logic                           load;
    logic                           at_end;

    // Load a result when the output register is free or draining
    always_comb
    begin
        load     = head_valid && (!valid_reg || !stall);
        at_end   = ({1'b0, idx_reg} + 1'b1) == head.cnt;
        pop      = load && at_end;
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = at_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= head.kind[idx_reg];
            data_reg <= head.data[idx_reg];
            last_reg <= at_end;
        end
    end

    assign valid = valid_reg;
    assign kind  = kind_reg;
    assign data  = data_reg;
    assign last  = last_reg;

endmodule

// File: rtl/url_qsd_core.sv
// Top level of the query-string splitter and percent decoder.
//
// One request-target byte transfers per cycle while req_stall is low; the parser
// resolves it in the same cycle and queues the one to four results it causes in
// a two-entry queue (a byte that causes none leaves nothing there). Results
// leave one per cycle from a registered output while res_stall is low, the
// first of them after the byte's transfer via the queue entry and the output
// register. The input sustains one byte per cycle while res_stall is low and
// bytes average at most one result; req_stall rises while both queue entries
// hold bundles, so the two-entry queue sets how long a burst can build.
module url_query_split_and_decode_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [7:0] byte_req,
    input  logic       final_req,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last
);

    url_qsd_pkg::bundle_t bundle;
    url_qsd_pkg::bundle_t head;
    logic accept;
    logic full;
    logic head_valid;
    logic pop;
    logic push;

    assign req_stall = full;
    assign accept    = req_valid && !full;
    assign push      = accept && (bundle.cnt != '0);

    url_qsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_req  (byte_req),
        .final_req (final_req),
        .bundle    (bundle)
    );

    url_qsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (bundle),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    url_qsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .valid      (res_valid),
        .stall      (res_stall),
        .kind       (kind),
        .data       (data),
        .last       (last)
    );

endmodule

// File: verif/qsd_checker.sv
// Checker for the query splitter: predicts results of each byte transfer and compares them.
module qsd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  logic [7:0] byte_req,
    input  logic       final_req,
    input  logic       res_valid,
    input  logic       res_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data,
    input  logic       last,
    output int         fails,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } qsd_res_t;

    // Parser state of the prediction
    logic [1:0] ph;
    logic [1:0] held_cnt;
    logic [7:0] held_b;
    logic       pair_live;

    qsd_res_t   step_q[$];
    qsd_res_t   decoded_q[$];
    qsd_res_t   want;
    int         fail_total = 0;
    int         open_count = 0;

    assign fails   = fail_total;
    assign pending = open_count;

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic int digit_of(input logic [7:0] c);
        if (c >= url_qsd_pkg::CH_ZERO && c <= url_qsd_pkg::CH_ZERO + 8'd9)
            return int'(c - url_qsd_pkg::CH_ZERO);
        if (c >= url_qsd_pkg::CH_LA && c <= url_qsd_pkg::CH_LA + 8'd5)
            return int'(c - url_qsd_pkg::CH_LA) + 10;
        if (c >= url_qsd_pkg::CH_UA && c <= url_qsd_pkg::CH_UA + 8'd5)
            return int'(c - url_qsd_pkg::CH_UA) + 10;
        return -1;
    endfunction

    // Read two characters as a C library would read base 16: blanks, sign, digits
    function automatic logic [7:0] hex_pair_value(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] ch [2];
        int         i;
        logic [7:0] acc;
        logic       minus;
        ch[0] = a;
        ch[1] = b;
        i     = 0;
        acc   = 8'd0;
        minus = 1'b0;
        while (i < 2 && (ch[i] == url_qsd_pkg::CH_SPACE ||
                         (ch[i] >= 8'd9 && ch[i] <= 8'd13)))
            i++;
        if (i < 2 && (ch[i] == url_qsd_pkg::CH_PLUS || ch[i] == url_qsd_pkg::CH_MINUS))
        begin
            minus = (ch[i] == url_qsd_pkg::CH_MINUS);
            i++;
        end
        while (i < 2 && digit_of(ch[i]) >= 0)
        begin
            acc = (acc << 4) + 8'(digit_of(ch[i]));
            i++;
        end
        return minus ? 8'd0 - acc : acc;
    endfunction

    function automatic logic [7:0] plus_to_space(input logic [7:0] b);
        return (b == url_qsd_pkg::CH_PLUS) ? url_qsd_pkg::CH_SPACE : b;
    endfunction

    function automatic logic [1:0] text_kind();
        return (ph == url_qsd_pkg::PH_VALUE) ? url_qsd_pkg::KIND_VALUE
                                             : url_qsd_pkg::KIND_KEY;
    endfunction

    task automatic put(input logic [1:0] k, input logic [7:0] d);
        step_q.push_back('{kind: k, data: d, last: 1'b0});
    endtask

    // Emit a held escape literally
    task automatic flush_escape();
        if (held_cnt != url_qsd_pkg::HOLD_NONE)
        begin
            put(text_kind(), url_qsd_pkg::CH_PCT);
            if (held_cnt == url_qsd_pkg::HOLD_BYTE)
                put(text_kind(), plus_to_space(held_b));
            held_cnt = url_qsd_pkg::HOLD_NONE;
            held_b   = 8'd0;
        end
    endtask

    task automatic take_query_byte(input logic [7:0] b);
        logic ends_segment;
        ends_segment = (b == url_qsd_pkg::CH_AMP) ||
                       (ph == url_qsd_pkg::PH_KEY && b == url_qsd_pkg::CH_EQ);
        if (held_cnt != url_qsd_pkg::HOLD_NONE && !ends_segment)
        begin
            if (held_cnt == url_qsd_pkg::HOLD_PCT)
            begin
                held_b   = b;
                held_cnt = url_qsd_pkg::HOLD_BYTE;
            end
            else
            begin
                put(text_kind(), hex_pair_value(held_b, b));
                held_cnt = url_qsd_pkg::HOLD_NONE;
                held_b   = 8'd0;
            end
        end
        else
        begin
            flush_escape();
            if (b == url_qsd_pkg::CH_AMP)
            begin
                if (pair_live)
                    put(url_qsd_pkg::KIND_PAIR_END, 8'd0);
                pair_live = 1'b0;
                ph        = url_qsd_pkg::PH_KEY;
            end
            else if (b == url_qsd_pkg::CH_EQ && ph == url_qsd_pkg::PH_KEY)
            begin
                ph        = url_qsd_pkg::PH_VALUE;
                pair_live = 1'b1;
            end
            else if (b == url_qsd_pkg::CH_PCT)
            begin
                held_cnt  = url_qsd_pkg::HOLD_PCT;
                pair_live = 1'b1;
            end
            else
            begin
                put(text_kind(), plus_to_space(b));
                pair_live = 1'b1;
            end
        end
    endtask

    task automatic clear_parser();
        ph        = url_qsd_pkg::PH_PRE;
        held_cnt  = url_qsd_pkg::HOLD_NONE;
        held_b    = 8'd0;
        pair_live = 1'b0;
    endtask

    // Work out the results of one byte and queue them
    task automatic predict_transfer(input logic [7:0] b, input logic fin);
        step_q.delete();
        if (ph == url_qsd_pkg::PH_PRE)
        begin
            if (b == url_qsd_pkg::CH_QMARK)
                ph = url_qsd_pkg::PH_KEY;
        end
        else
        begin
            take_query_byte(b);
        end
        if (fin)
        begin
            flush_escape();
            if (pair_live)
                put(url_qsd_pkg::KIND_PAIR_END, 8'd0);
            put(url_qsd_pkg::KIND_TARGET_END, 8'd0);
            clear_parser();
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            decoded_q.push_back(step_q[i]);
    endtask

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            decoded_q.delete();
            open_count = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_transfer(byte_req, final_req);
            if (res_valid && !res_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    report_mismatch($sformatf("result kind=%0d data=%02h last=%0b with none due",
                                              kind, data, last));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, due %0d", kind, want.kind));
                    if (data !== want.data)
                        report_mismatch($sformatf("data %02h, due %02h", data, want.data));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, due %0b", last, want.last));
                end
            end
            open_count = decoded_q.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Testbench top: clock, reset, byte stimulus, output stall and verdict for the query splitter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       req_valid   = 1'b0;
    logic       req_stall;
    logic [7:0] byte_req    = 8'd0;
    logic       final_req   = 1'b0;
    logic       res_valid;
    logic       res_stall   = 1'b0;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    int         fails;
    int         pending;

    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         items_sent  = 0;
    logic [7:0] target_q[$];
    string      hex_chars   = "0123456789abcdefABCDEF";

    url_query_split_and_decode_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .byte_req  (byte_req),
        .final_req (final_req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

    qsd_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .byte_req  (byte_req),
        .final_req (final_req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .fails     (fails),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the output at random
    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Hold off, then offer one byte until it is taken
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        byte_req  <= b;
        final_req <= fin;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Send the built target, the last byte flagged final
    task automatic send_target();
        foreach (target_q[i])
            send_byte(target_q[i], i == target_q.size() - 1);
        target_q.delete();
    endtask

    // Drop valid and hold until every due result has come
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] escape_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return hex_chars[$urandom_range(0, 21)];
            5:             return ($urandom_range(0, 1) != 0) ? url_qsd_pkg::CH_SPACE
                                                             : 8'($urandom_range(9, 13));
            6:             return ($urandom_range(0, 1) != 0) ? url_qsd_pkg::CH_PLUS
                                                             : url_qsd_pkg::CH_MINUS;
            7:             return 8'($urandom_range(0, 255));
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return url_qsd_pkg::CH_EQ;
                    1:       return url_qsd_pkg::CH_AMP;
                    default: return url_qsd_pkg::CH_PCT;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7A));
            4:          return url_qsd_pkg::CH_PLUS;
            5:          return 8'($urandom_range(8'h30, 8'h39));
            6:          return url_qsd_pkg::CH_QMARK;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append n text characters, some of them escapes, a few escapes cut short
    task automatic push_text(input int n);
        int tail;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                target_q.push_back(url_qsd_pkg::CH_PCT);
                tail = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 2;
                for (int j = 0; j < tail; j++)
                    target_q.push_back(escape_char());
            end
            else
            begin
                target_q.push_back(text_char());
            end
        end
    endtask

    // Build one target: mostly well-formed queries, some noise
    task automatic build_target();
        logic [7:0] b;
        int         n_pairs;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                target_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                b = 8'($urandom_range(0, 255));
                target_q.push_back((b == url_qsd_pkg::CH_QMARK) ? url_qsd_pkg::CH_SPACE : b);
            end
            target_q.push_back(url_qsd_pkg::CH_QMARK);
            n_pairs = $urandom_range(1, 4);
            for (int p = 0; p < n_pairs; p++)
            begin
                if (p > 0)
                begin
                    target_q.push_back(url_qsd_pkg::CH_AMP);
                    if ($urandom_range(0, 7) == 0)
                        target_q.push_back(url_qsd_pkg::CH_AMP);
                end
                push_text($urandom_range(0, 4));
                if ($urandom_range(0, 4) != 0)
                begin
                    target_q.push_back(url_qsd_pkg::CH_EQ);
                    push_text($urandom_range(0, 5));
                end
            end
            if ($urandom_range(0, 7) == 0)
                target_q.push_back(url_qsd_pkg::CH_AMP);
        end
    endtask

    task automatic run_random(input int goal);
        while (items_sent < goal)
        begin
            build_target();
            send_target();
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle_pct = 6;
        rx_idle_pct = 87;

        // Directed: byte extremes, '+', hex, negative hex, empty pairs, '=' only pair,
        // escape cut by '=' in a key, '=' taken as hex in a value, later '?',
        // escape flushed by the final byte, then a target without '?'
        target_q = '{url_qsd_pkg::CH_QMARK, 8'h00, 8'hFF, url_qsd_pkg::CH_PLUS,
                     url_qsd_pkg::CH_PCT, "4", "1", url_qsd_pkg::CH_EQ,
                     url_qsd_pkg::CH_PCT, url_qsd_pkg::CH_MINUS, "1", url_qsd_pkg::CH_AMP,
                     url_qsd_pkg::CH_AMP, url_qsd_pkg::CH_EQ, url_qsd_pkg::CH_AMP, "k",
                     url_qsd_pkg::CH_PCT, url_qsd_pkg::CH_EQ, "v", url_qsd_pkg::CH_PCT,
                     url_qsd_pkg::CH_EQ, "2", url_qsd_pkg::CH_QMARK, url_qsd_pkg::CH_PCT,
                     "7"};
        send_target();
        target_q = '{"x"};
        send_target();
        drain();

        run_random(80);
        drain();

        tx_idle_pct = 87;
        rx_idle_pct = 6;
        run_random(145);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(205);
        drain();

        repeat (16) @(negedge clk);
        if (fails == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // End a hung run
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
